// File: rtl/cssc_pkg.sv
// Shared constants and types for the crane schedule sandwich checker.
// No dependencies; every other file in rtl/ imports this package.
package cssc_pkg;

    localparam int MAX_CRANES_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int CRANE_W = 4;
    localparam int NUM_W   = 5;
    localparam int DUR_W   = 16;
    localparam int OUT_W   = 32;

    localparam logic [NUM_W-1:0] NUM_CRANES_RST = 5'd2;

    // Per-beat control broadcast to every cell of both chains.
    typedef struct packed {
        logic clr;   // new schedule starts with this beat
        logic upd;   // beat is good and changes the schedule state
    } cell_ctl_t;

endpackage

// File: rtl/cssc_crane_cell.sv
// One crane cell: holds the earliest free time of a single crane.
// Depends on cssc_pkg. Its neighbor on the right tells it whether the
// target crane of the current beat lies to its right.
module cssc_crane_cell #(
    parameter int INDEX     = 0,
    parameter int TIME_BITS = cssc_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cssc_pkg::cell_ctl_t         ctl,
    input  logic [cssc_pkg::CRANE_W-1:0] crane,
    input  logic [TIME_BITS-1:0]        finish,
    input  logic                        left_in,
    output logic                        left_out,
    output logic [TIME_BITS-1:0]        sel_time
);
    import cssc_pkg::*;

    localparam int IW = (INDEX >= (1 << CRANE_W)) ? $clog2(INDEX + 1) + 1 : CRANE_W + 1;

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    logic [TIME_BITS-1:0] time_eff;
    logic                 self_hit;

    assign self_hit = (IW'(crane) == IW'(INDEX));
    // A cell is left of the target when any cell to its right is the target.
    assign left_out = left_in | self_hit;

    assign time_eff = ctl.clr ? '0 : time_reg;
    assign sel_time = self_hit ? time_eff : '0;

    always_comb
    begin
        time_next = time_eff;
        if (ctl.upd)
        begin
            if (self_hit)
            begin
                time_next = finish;
            end
            else if (left_in && (time_eff < finish))
            begin
                time_next = finish;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else
        begin
            time_reg <= time_next;
        end
    end

endmodule

// File: rtl/cssc_hist_cell.sv
// One history cell: holds one earlier item and checks it against the
// current beat. Depends on cssc_pkg. Entries shift to the next cell.
module cssc_hist_cell #(
    parameter int STEP      = 1,
    parameter int TIME_BITS = cssc_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  cssc_pkg::cell_ctl_t          ctl,
    input  logic                         win_en,
    input  logic [cssc_pkg::CRANE_W-1:0] crane,
    input  logic [TIME_BITS-1:0]         start,
    input  logic [TIME_BITS-1:0]         finish,
    input  logic [cssc_pkg::CRANE_W-1:0] prev_crane,
    input  logic [TIME_BITS-1:0]         prev_start,
    input  logic [TIME_BITS-1:0]         prev_finish,
    output logic [cssc_pkg::CRANE_W-1:0] hold_crane,
    output logic [TIME_BITS-1:0]         hold_start,
    output logic [TIME_BITS-1:0]         hold_finish,
    output logic                         hit
);
    import cssc_pkg::*;

    localparam int GW = $clog2(STEP + (1 << CRANE_W)) + 1;

    logic [CRANE_W-1:0]   crane_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] finish_reg;
    logic [GW-1:0]        gap_lim;
    logic                 sandwiched;
    logic                 overlap;

    assign hold_crane  = crane_reg;
    assign hold_start  = start_reg;
    assign hold_finish = finish_reg;

    // The earlier item is sandwiched when the crane gap exceeds its distance back.
    assign gap_lim    = GW'(crane_reg) + GW'(STEP);
    assign sandwiched = GW'(crane) > gap_lim;
    // max(start) < min(finish) written as four independent compares.
    assign overlap = (start < finish_reg) && (start_reg < finish)
                     && (start < finish) && (start_reg < finish_reg);
    assign hit = win_en && sandwiched && overlap;

    always_ff @(posedge clk)
    begin
        if (ctl.upd)
        begin
            crane_reg  <= prev_crane;
            start_reg  <= prev_start;
            finish_reg <= prev_finish;
        end
    end

endmodule

// File: rtl/crane_schedule_sandwich_checker_unit.sv
// Top level of the crane schedule sandwich checker: crane cell chain,
// history cell chain and the output register. Depends on cssc_pkg,
// cssc_crane_cell and cssc_hist_cell.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | in_valid/in_ready  | new_schedule, crane_index, processing_time
//   output   | out_valid/out_ready| start_time, finish_time, sandwich_conflict,
//            |                    | infeasible, bad_crane
//   config   | cfg_we             | cfg_wdata (num_cranes)
//
// One beat per cycle when not stalled; the result appears in the output register
// in the cycle after its input beat. The path through the crane free-time select,
// the saturating add and the per-cell compares sets the clock.
// A new beat is taken while the output register is empty or being drained.
// Reset clears crane times, history count and flag, and sets num_cranes to 2.
module crane_schedule_sandwich_checker_unit #(
    parameter int MAX_CRANES = cssc_pkg::MAX_CRANES_DEF,
    parameter int TIME_BITS  = cssc_pkg::TIME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         new_schedule,
    input  logic [cssc_pkg::CRANE_W-1:0] crane_index,
    input  logic [cssc_pkg::DUR_W-1:0]   processing_time,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cssc_pkg::OUT_W-1:0]   start_time,
    output logic [cssc_pkg::OUT_W-1:0]   finish_time,
    output logic                         sandwich_conflict,
    output logic                         infeasible,
    output logic                         bad_crane,
    input  logic                         cfg_we,
    input  logic [cssc_pkg::NUM_W-1:0]   cfg_wdata
);
    import cssc_pkg::*;

    localparam int HIST_DEPTH = MAX_CRANES - 2;
    localparam int HIST_CELLS = (HIST_DEPTH > 0) ? HIST_DEPTH : 1;
    localparam int SEEN_W     = $clog2(HIST_CELLS + 1);
    localparam int CNT_W      = ($clog2(MAX_CRANES + 1) > NUM_W) ?
                                $clog2(MAX_CRANES + 1) : NUM_W;

    logic [NUM_W-1:0]     num_cranes_reg;
    logic [SEEN_W-1:0]    seen_reg;
    logic [SEEN_W-1:0]    seen_next;
    logic [SEEN_W-1:0]    seen_eff;
    logic                 flag_reg;
    logic                 flag_next;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     start_time_reg;
    logic [OUT_W-1:0]     finish_time_reg;
    logic                 conflict_reg;
    logic                 infeasible_reg;
    logic                 bad_reg;

    logic                 accept;
    logic [CNT_W-1:0]     cranes_eff;
    logic                 bad;
    cell_ctl_t            ctl;

    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] finish;
    logic                 conflict;
    logic [63:0]          start_wide;
    logic [63:0]          finish_wide;

    logic [MAX_CRANES:0]                   left_chain;
    logic [MAX_CRANES-1:0][TIME_BITS-1:0]  sel_times;

    logic [HIST_CELLS:0][CRANE_W-1:0]      h_crane;
    logic [HIST_CELLS:0][TIME_BITS-1:0]    h_start;
    logic [HIST_CELLS:0][TIME_BITS-1:0]    h_finish;
    logic [HIST_CELLS-1:0]                 win_en;
    logic [HIST_CELLS-1:0]                 hits;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign cranes_eff = (CNT_W'(num_cranes_reg) > CNT_W'(MAX_CRANES)) ?
                        CNT_W'(MAX_CRANES) : CNT_W'(num_cranes_reg);
    assign bad = (CNT_W'(crane_index) >= cranes_eff);

    assign ctl.clr = accept && new_schedule;
    assign ctl.upd = accept && !bad;

    // Crane cell chain; the "left of target" mark travels from right to left.
    assign left_chain[MAX_CRANES] = 1'b0;
    for (genvar k = 0; k < MAX_CRANES; k++)
    begin : g_crane
        cssc_crane_cell #(
            .INDEX     (k),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .crane    (crane_index),
            .finish   (finish),
            .left_in  (left_chain[k+1]),
            .left_out (left_chain[k]),
            .sel_time (sel_times[k])
        );
    end

    always_comb
    begin
        start = '0;
        for (int k = 0; k < MAX_CRANES; k++)
        begin
            start = start | sel_times[k];
        end
    end

    assign sum    = {1'b0, start} + (TIME_BITS + 1)'(processing_time);
    assign finish = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    assign seen_eff = ctl.clr ? '0 : seen_reg;

    // History chain: cell zero takes the current beat, the others shift.
    assign h_crane[0]  = crane_index;
    assign h_start[0]  = start;
    assign h_finish[0] = finish;
    for (genvar i = 0; i < HIST_CELLS; i++)
    begin : g_hist
        // A cell is in the window when it holds a real entry and it lies
        // within num_cranes - 2 steps back.
        assign win_en[i] = (HIST_DEPTH > 0) && (32'(seen_eff) > i)
                           && (32'(cranes_eff) > i + 2);
        cssc_hist_cell #(
            .STEP      (i + 1),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .win_en      (win_en[i]),
            .crane       (crane_index),
            .start       (start),
            .finish      (finish),
            .prev_crane  (h_crane[i]),
            .prev_start  (h_start[i]),
            .prev_finish (h_finish[i]),
            .hold_crane  (h_crane[i+1]),
            .hold_start  (h_start[i+1]),
            .hold_finish (h_finish[i+1]),
            .hit         (hits[i])
        );
    end

    assign conflict = |hits;

    always_comb
    begin
        flag_next = ctl.clr ? 1'b0 : flag_reg;
        if (ctl.upd && conflict)
        begin
            flag_next = 1'b1;
        end
    end

    always_comb
    begin
        seen_next = seen_eff;
        if (ctl.upd && (seen_eff < SEEN_W'(HIST_CELLS)))
        begin
            seen_next = seen_eff + 1'b1;
        end
    end

    assign start_wide  = 64'(start);
    assign finish_wide = 64'(finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cranes_reg <= NUM_CRANES_RST;
            seen_reg       <= '0;
            flag_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_cranes_reg <= cfg_wdata;
            end
            if (accept)
            begin
                seen_reg <= seen_next;
                flag_reg <= flag_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_time_reg  <= bad ? '0 : start_wide[OUT_W-1:0];
            finish_time_reg <= bad ? '0 : finish_wide[OUT_W-1:0];
            conflict_reg    <= !bad && conflict;
            infeasible_reg  <= flag_next;
            bad_reg         <= bad;
        end
    end

    assign out_valid         = out_valid_reg;
    assign start_time        = start_time_reg;
    assign finish_time       = finish_time_reg;
    assign sandwich_conflict = conflict_reg;
    assign infeasible        = infeasible_reg;
    assign bad_crane         = bad_reg;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_crane) |-> (start_time == '0 && finish_time == '0
                                       && !sandwich_conflict))
        else $error("bad crane beat carries nonzero schedule fields");

    a_conflict_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sandwich_conflict) |-> infeasible)
        else $error("conflict reported without infeasible flag");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (flag_reg && !(accept && new_schedule)) |=> flag_reg)
        else $error("infeasible flag dropped without a new schedule");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(HIST_CELLS))
        else $error("history count beyond history depth");

endmodule

// File: bench/crane_schedule_sandwich_checker_unit_tb.sv
// Testbench for crane_schedule_sandwich_checker_unit: directed table, random schedules and a
// run of long jobs, each result beat checked against the table's expected values or an in-bench schedule predictor.
// Depends on cssc_pkg and the RTL top level; needs no files or arguments.
module crane_schedule_sandwich_checker_unit_tb;
    import cssc_pkg::*;

    localparam int CRANES = MAX_CRANES_DEF;
    localparam int HIST = CRANES - 2;
    localparam logic [OUT_W-1:0] TIME_TOP = '1;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DIR_ROWS = 26;
    localparam int PHASES = 10;
    localparam int PHASE_BEATS = 160;
    localparam int LONG_BEATS = 19;
    localparam int RESULT_SLOTS = 16;
    localparam logic [PHASES-1:0][NUM_W-1:0] PHASE_COUNTS =
        {5'd12, 5'd9, 5'd17, 5'd31, 5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd16};

    typedef enum logic [1:0] {ROW_BEAT, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [OUT_W-1:0] start;
        logic [OUT_W-1:0] finish;
        logic             conflict;
        logic             infeasible;
        logic             bad;
    } crane_result_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               ns;
        logic [CRANE_W-1:0] crane;
        logic [DUR_W-1:0]   dur;
        logic [NUM_W-1:0]   count;
        logic               typed;
        crane_result_t      want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               new_schedule = 1'b0;
    logic [CRANE_W-1:0] crane_index = '0;
    logic [DUR_W-1:0]   processing_time = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [OUT_W-1:0]   start_time;
    logic [OUT_W-1:0]   finish_time;
    logic               sandwich_conflict;
    logic               infeasible;
    logic               bad_crane;
    logic               cfg_we = 1'b0;
    logic [NUM_W-1:0]   cfg_wdata = '0;

    // Predictor state: the schedule as the block should hold it.
    logic [NUM_W-1:0]   crane_count = NUM_CRANES_RST;
    logic [OUT_W-1:0]   free_at [CRANES];
    logic [CRANE_W-1:0] past_crane [HIST];
    logic [OUT_W-1:0]   past_start [HIST];
    logic [DUR_W-1:0]   past_dur [HIST];
    int                 past_count;
    logic               infeasible_seen;

    // Expected results waiting for their beat, kept as a small ring.
    crane_result_t      result_ring [RESULT_SLOTS];
    int                 result_wr = 0;
    int                 result_rd = 0;
    stim_row_t          dir_rows [DIR_ROWS];
    int fail_count = 0;
    int beat_count = 0;
    int conflict_count = 0;
    int bad_count = 0;
    int setting_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold = 0;

    crane_schedule_sandwich_checker_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .new_schedule     (new_schedule),
        .crane_index      (crane_index),
        .processing_time  (processing_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .start_time       (start_time),
        .finish_time      (finish_time),
        .sandwich_conflict(sandwich_conflict),
        .infeasible       (infeasible),
        .bad_crane        (bad_crane),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [OUT_W-1:0] sat_time(input logic [OUT_W-1:0] a,
                                                  input logic [DUR_W-1:0] b);
        logic [OUT_W:0] sum;
        sum = {1'b0, a} + (OUT_W + 1)'(b);
        return sum[OUT_W] ? TIME_TOP : sum[OUT_W-1:0];
    endfunction

    function automatic void clear_schedule();
        for (int k = 0; k < CRANES; k++)
            free_at[k] = '0;
        past_count = 0;
        infeasible_seen = 1'b0;
    endfunction

    function automatic int cranes_in_use();
        return (int'(crane_count) > CRANES) ? CRANES : int'(crane_count);
    endfunction

    function automatic crane_result_t schedule_step(input logic ns,
                                                    input logic [CRANE_W-1:0] crane,
                                                    input logic [DUR_W-1:0] dur);
        crane_result_t    r;
        int               in_use;
        int               win;
        logic [OUT_W-1:0] st;
        logic [OUT_W-1:0] fin;
        logic [OUT_W-1:0] pf;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] hi;
        r = '0;
        in_use = cranes_in_use();
        if (ns)
            clear_schedule();
        if (int'(crane) >= in_use)
        begin
            r.infeasible = infeasible_seen;
            r.bad = 1'b1;
            return r;
        end
        st = free_at[crane];
        fin = sat_time(st, dur);
        free_at[crane] = fin;
        // Cranes to the left may not stay behind, or they would have to cross.
        for (int k = 0; k < int'(crane); k++)
            if (free_at[k] < fin)
                free_at[k] = fin;
        win = (in_use >= 2) ? in_use - 2 : 0;
        if (win > past_count)
            win = past_count;
        for (int s = 1; s <= win; s++)
        begin
            if (int'(crane) > int'(past_crane[s-1]) + s)
            begin
                pf = sat_time(past_start[s-1], past_dur[s-1]);
                lo = (st > past_start[s-1]) ? st : past_start[s-1];
                hi = (fin < pf) ? fin : pf;
                if (lo < hi)
                    r.conflict = 1'b1;
            end
        end
        if (r.conflict)
            infeasible_seen = 1'b1;
        for (int k = HIST - 1; k > 0; k--)
        begin
            past_crane[k] = past_crane[k-1];
            past_start[k] = past_start[k-1];
            past_dur[k] = past_dur[k-1];
        end
        past_crane[0] = crane;
        past_start[0] = st;
        past_dur[0] = dur;
        if (past_count < HIST)
            past_count++;
        r.start = st;
        r.finish = fin;
        r.infeasible = infeasible_seen;
        return r;
    endfunction

    function automatic stim_row_t beat_row(input logic ns, input int crane, input int dur);
        stim_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.ns = ns;
        row.crane = CRANE_W'(crane);
        row.dur = DUR_W'(dur);
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic ns, input int crane, input int dur,
                                            input longint st, input longint fin,
                                            input logic c, input logic inf, input logic bad);
        stim_row_t row;
        row = beat_row(ns, crane, dur);
        row.typed = 1'b1;
        row.want.start = OUT_W'(st);
        row.want.finish = OUT_W'(fin);
        row.want.conflict = c;
        row.want.infeasible = inf;
        row.want.bad = bad;
        return row;
    endfunction

    function automatic stim_row_t count_row(input int count);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.count = NUM_W'(count);
        return row;
    endfunction

    task automatic send_beat(input logic ns, input logic [CRANE_W-1:0] crane,
                             input logic [DUR_W-1:0] dur, input logic typed,
                             input crane_result_t want);
        crane_result_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        new_schedule <= ns;
        crane_index <= crane;
        processing_time <= dur;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = schedule_step(ns, crane, dur);
        result_ring[result_wr % RESULT_SLOTS] = typed ? want : predicted;
        result_wr++;
        beat_count++;
    endtask

    // Mostly in-range cranes with zero, short, random and longest jobs, so schedules build real history; a new
    // schedule starts about every thirty beats.
    task automatic send_random_beat();
        int                 in_use;
        logic [CRANE_W-1:0] crane;
        logic [DUR_W-1:0]   dur;
        in_use = cranes_in_use();
        if (in_use == 0 || $urandom_range(9) == 0)
            crane = CRANE_W'($urandom_range(CRANES - 1));
        else
            crane = CRANE_W'($urandom_range(in_use - 1));
        case ($urandom_range(7))
            0: dur = '0;
            1: dur = '1;
            2, 3, 4: dur = DUR_W'($urandom_range(24));
            default: dur = DUR_W'($urandom);
        endcase
        send_beat($urandom_range(99) < 3, crane, dur, 1'b0, '0);
    endtask

    task automatic schedule_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (result_wr != result_rd)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_crane_count(input logic [NUM_W-1:0] count);
        schedule_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        crane_count = count;
        setting_count++;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        crane_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_wr == result_rd)
            begin
                $error("result beat arrived with nothing pending");
                fail_count++;
            end
            else
            begin
                want = result_ring[result_rd % RESULT_SLOTS];
                result_rd++;
                check_field("start_time", want.start, start_time);
                check_field("finish_time", want.finish, finish_time);
                check_field("sandwich_conflict", OUT_W'(want.conflict),
                            OUT_W'(sandwich_conflict));
                check_field("infeasible", OUT_W'(want.infeasible), OUT_W'(infeasible));
                check_field("bad_crane", OUT_W'(want.bad), OUT_W'(bad_crane));
                conflict_count += int'(want.conflict);
                bad_count += int'(want.bad);
            end
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clear_schedule();
        // Two cranes after reset: empty job, longest job, cranes past the count.
        dir_rows[0]  = typed_row(1'b0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
        dir_rows[1]  = typed_row(1'b0, 1, 65535, 0, 65535, 1'b0, 1'b0, 1'b0);
        dir_rows[2]  = typed_row(1'b0, 2, 3, 0, 0, 1'b0, 1'b0, 1'b1);
        dir_rows[3]  = typed_row(1'b0, 15, 65535, 0, 0, 1'b0, 1'b0, 1'b1);
        dir_rows[4]  = typed_row(1'b0, 0, 100, 65535, 65635, 1'b0, 1'b0, 1'b0);
        // A count of zero makes every crane bad; the clear still happens.
        dir_rows[5]  = count_row(0);
        dir_rows[6]  = typed_row(1'b1, 0, 5, 0, 0, 1'b0, 1'b0, 1'b1);
        // Full width: a sandwich right away, then zero duration and far cranes.
        dir_rows[7]  = count_row(16);
        dir_rows[8]  = beat_row(1'b1, 0, 10);
        dir_rows[9]  = beat_row(1'b0, 5, 10);
        dir_rows[10] = beat_row(1'b0, 1, 0);
        dir_rows[11] = beat_row(1'b0, 3, 6);
        dir_rows[12] = beat_row(1'b0, 15, 65535);
        dir_rows[13] = beat_row(1'b0, 0, 1);
        dir_rows[14] = beat_row(1'b0, 14, 7);
        // Oversized count behaves as the full width.
        dir_rows[15] = count_row(31);
        dir_rows[16] = beat_row(1'b0, 15, 3);
        dir_rows[17] = beat_row(1'b0, 8, 2);
        // Three cranes: the flag stays set on a bad beat, a clear on a bad beat drops it.
        dir_rows[18] = count_row(3);
        dir_rows[19] = typed_row(1'b0, 15, 1, 0, 0, 1'b0, 1'b1, 1'b1);
        dir_rows[20] = typed_row(1'b1, 15, 1, 0, 0, 1'b0, 1'b0, 1'b1);
        dir_rows[21] = typed_row(1'b0, 0, 9, 0, 9, 1'b0, 1'b0, 1'b0);
        dir_rows[22] = beat_row(1'b0, 2, 9);
        // A single crane is never checked.
        dir_rows[23] = count_row(1);
        dir_rows[24] = beat_row(1'b0, 1, 4);
        dir_rows[25] = beat_row(1'b0, 0, 65535);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 7;
        rx_stall_pct = 7;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
                set_crane_count(dir_rows[i].count);
            else
                send_beat(dir_rows[i].ns, dir_rows[i].crane, dir_rows[i].dur,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            set_crane_count(PHASE_COUNTS[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
            endcase
            // Hold the output off for a while so the block fills and stops taking beats.
            if (p == 0)
                rx_hold = 80;
            repeat (PHASE_BEATS) send_random_beat();
        end

        // Pile long jobs on the rightmost crane so every crane time climbs together.
        set_crane_count(NUM_W'(CRANES));
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        send_beat(1'b1, CRANE_W'(CRANES - 1), '1, 1'b0, '0);
        repeat (LONG_BEATS) send_beat(1'b0, CRANE_W'(CRANES - 1), '1, 1'b0, '0);
        repeat (60) send_random_beat();

        schedule_drain();
        repeat (8) @(posedge clk);
        $display("Ran %0d beats over %0d crane-count settings, including a run of long jobs.",
                 beat_count, setting_count);
        $display("Results held %0d sandwich conflicts and %0d bad-crane beats.",
                 conflict_count, bad_count);
        if (fail_count == 0 && result_wr == result_rd)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
